// File: design/qmr_pkg.sv
// ----------------------------------------------------------------------------
// qmr_pkg: shared types and constants for the quaternion multiply block.
// Holds the word structs, controller states and datapath command codes.
// ----------------------------------------------------------------------------
package qmr_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CNT_W    = 17;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd97;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
  } qmr_in_t;

  typedef struct packed {
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;
    logic signed [31:0] prod_z;
    logic signed [31:0] prod_w;
    logic               renormalized;
  } qmr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } qmr_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture input word
    logic mul_step;  // one product of the sixteen
    logic sat;       // saturate the four sums
    logic sq_step;   // one square of the four
    logic sqrt_init;
    logic sqrt_step; // one result bit of the root
    logic div_init;  // start a divide of component idx
    logic div_step;  // one quotient bit
    logic div_fin;   // write back component idx
    logic [3:0] idx; // product or component index
    logic [5:0] bit_idx;
  } qmr_cmd_t;

  typedef struct packed {
    logic mag_zero;
  } qmr_stat_t;

  // Product table: operand selects and sign of each of the sixteen terms.
  // Operand codes: 0..3 = a x,y,z,w; 4..7 = b x,y,z,w.
  function automatic logic [2:0] op_p(input logic [3:0] k);
    logic [2:0] t [16];
    t = '{3'd7,3'd3,3'd1,3'd2, 3'd7,3'd3,3'd2,3'd0,
          3'd7,3'd3,3'd0,3'd1, 3'd3,3'd0,3'd1,3'd2};
    return t[k];
  endfunction

  function automatic logic [2:0] op_q(input logic [3:0] k);
    logic [2:0] t [16];
    t = '{3'd0,3'd4,3'd6,3'd5, 3'd1,3'd5,3'd4,3'd6,
          3'd2,3'd6,3'd5,3'd4, 3'd7,3'd4,3'd5,3'd6};
    return t[k];
  endfunction

  function automatic logic op_neg(input logic [3:0] k);
    logic [15:0] t;
    t = 16'b1110_1000_1000_1000; // bit k set = subtract
    return t[k];
  endfunction

endpackage

// File: design/qmr_ctrl.sv
// ----------------------------------------------------------------------------
// qmr_ctrl: sequencer for the quaternion multiply block.
// Steps the datapath through products, roots and divides; owns the counter.
// ----------------------------------------------------------------------------
module qmr_ctrl
  import qmr_pkg::*;
#(
  parameter logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_RESET
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  qmr_stat_t           stat,
  output qmr_cmd_t            cmd,
  output logic                renorm
);

  qmr_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [CNT_W-1:0] calls_r, calls_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic renorm_r, renorm_nxt;
  logic [CNT_W-1:0] inc;

  assign inc = calls_r + 1'b1;
  assign renorm = renorm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= RESET_PERIOD;
    end else if (cfg_we) begin
      period_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      comp_r   <= '0;
      calls_r  <= '0;
      renorm_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      comp_r   <= comp_nxt;
      calls_r  <= calls_nxt;
      renorm_r <= renorm_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    comp_nxt   = comp_r;
    calls_nxt  = calls_r;
    renorm_nxt = renorm_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd15) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (inc > {1'b0, period_r}) begin
          calls_nxt  = '0;
          renorm_nxt = 1'b1;
          state_nxt  = ST_SQ;
          cnt_nxt    = '0;
        end else begin
          calls_nxt  = inc;
          renorm_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd4) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = 6'd31;
        end
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (stat.mag_zero) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
            comp_nxt  = '0;
            cnt_nxt   = 6'd63;
          end
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          cnt_nxt  = 6'd63;
          comp_nxt = comp_r + 2'd1;
          if (comp_r == 2'd3) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // In ST_SQ the count runs 0..4: the init of the root comes on the last.
  // In ST_DIV count 63 is the divide init, 62..0 the quotient bits and the
  // write back happens with the last bit.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.idx     = {2'b00, comp_r};
    cmd.bit_idx = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.idx      = cnt_r[3:0];
      end
      ST_SAT: cmd.sat = 1'b1;
      ST_SQ: begin
        cmd.idx = cnt_r[3:0];
        if (cnt_r == 6'd4) begin
          cmd.sqrt_init = 1'b1;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_DIV: begin
        if (cnt_r == 6'd63) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
          cmd.div_fin  = (cnt_r == 6'd0);
        end
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  // The call counter never runs past the largest period plus one.
  a_calls_bound: assert property (@(posedge clk) disable iff (!rst_n)
    calls_r <= 17'd65536) else $error("call counter out of range");
  // A new word is only taken from idle.
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_MUL) else $error("bad accept");
  // Renormalization clears the counter.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAT && state_nxt == ST_SQ) |=> calls_r == '0)
    else $error("counter not cleared");

endmodule

// File: design/qmr_dp.sv
// ----------------------------------------------------------------------------
// qmr_dp: datapath with a 32x32 product multiplier, a squarer, a bit-serial
// root and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module qmr_dp
  import qmr_pkg::*;
(
  input  logic      clk,
  input  qmr_in_t   in_data,
  input  qmr_cmd_t  cmd,
  input  logic      renorm,
  output qmr_stat_t stat,
  output qmr_out_t  out_data
);

  logic signed [31:0] op_r [8];
  logic signed [34:0] acc_r [4];
  logic signed [31:0] res_r [4];
  logic [63:0] sumsq_r;        // sum of each square's floor over four
  logic [1:0]  sumlo_r [4];
  logic [63:0] rem_r;
  logic [31:0] root_r;
  logic [63:0] sq_rem_r;
  logic [62:0] dividend_r;
  logic [62:0] quot_r;
  logic [32:0] drem_r;

  logic signed [31:0] mp, mq;
  logic signed [63:0] mprod;
  logic signed [33:0] term;
  logic [1:0]  comp;
  logic signed [31:0] sq_in;
  logic signed [63:0] sq_full;
  logic [3:0] lo_sum;
  logic [65:0] trial;
  logic [65:0] sq_try;
  logic [32:0] dshift;
  logic [31:0] mag;

  assign mp    = op_r[op_p(cmd.idx)];
  assign mq    = op_r[op_q(cmd.idx)];
  assign mprod = mp * mq;
  assign term  = 34'(mprod >>> 30);
  assign comp  = cmd.idx[3:2];

  assign sq_in   = res_r[cmd.idx[1:0]];
  assign sq_full = sq_in * sq_in;
  assign lo_sum  = {2'b0, sumlo_r[0]} + {2'b0, sumlo_r[1]}
                 + {2'b0, sumlo_r[2]} + {2'b0, sumlo_r[3]};

  // Root: classic one-bit-per-step; root_r carries the partial root.
  assign sq_try = {sq_rem_r[63:0], rem_r[63:62]};
  assign trial  = {32'b0, root_r, 2'b01};

  assign dshift = {drem_r[31:0], dividend_r[cmd.bit_idx]};
  assign mag    = sq_in[31] ? 32'(-{1'b0, sq_in}) : sq_in;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r[0] <= in_data.a_x; op_r[1] <= in_data.a_y;
      op_r[2] <= in_data.a_z; op_r[3] <= in_data.a_w;
      op_r[4] <= in_data.b_x; op_r[5] <= in_data.b_y;
      op_r[6] <= in_data.b_z; op_r[7] <= in_data.b_w;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
      sumsq_r <= '0;
    end
    if (cmd.mul_step) begin
      acc_r[comp] <= op_neg(cmd.idx) ? acc_r[comp] - 35'(term)
                                     : acc_r[comp] + 35'(term);
    end
    if (cmd.sat) begin
      for (int i = 0; i < 4; i++) begin
        if (acc_r[i] > 35'sd2147483647) res_r[i] <= 32'h7fffffff;
        else if (acc_r[i] < -35'sd2147483648) res_r[i] <= 32'h80000000;
        else res_r[i] <= acc_r[i][31:0];
      end
    end
    if (cmd.sq_step) begin
      sumsq_r <= sumsq_r + {2'b0, sq_full[63:2]};
      sumlo_r[cmd.idx[1:0]] <= sq_full[1:0];
    end
    if (cmd.sqrt_init) begin
      rem_r    <= sumsq_r + {62'b0, lo_sum[3:2]};
      root_r   <= '0;
      sq_rem_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rem_r <= {rem_r[61:0], 2'b00};
      if (sq_try >= trial) begin
        sq_rem_r <= 64'(sq_try - trial);
        root_r   <= {root_r[30:0], 1'b1};
      end else begin
        sq_rem_r <= sq_try[63:0];
        root_r   <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      dividend_r <= {2'b00, mag, 29'b0};
      drem_r     <= '0;
      quot_r     <= '0;
    end
    if (cmd.div_step) begin
      if (dshift >= {1'b0, root_r}) begin
        drem_r <= dshift - {1'b0, root_r};
        quot_r <= {quot_r[61:0], 1'b1};
      end else begin
        drem_r <= dshift;
        quot_r <= {quot_r[61:0], 1'b0};
      end
    end
    if (cmd.div_fin) begin
      // Quotient of the final bit is folded in here.
      if (sq_in[31]) begin
        if (|quot_r[61:30] || (quot_r[30] && |quot_r[29:0]))
          res_r[cmd.idx[1:0]] <= 32'h80000000;
        else
          res_r[cmd.idx[1:0]] <= 32'(-{1'b0, quot_r[30:0], (dshift >= {1'b0, root_r})});
      end else begin
        if (|quot_r[61:31] || quot_r[30])
          res_r[cmd.idx[1:0]] <= 32'h7fffffff;
        else
          res_r[cmd.idx[1:0]] <= {1'b0, quot_r[29:0], (dshift >= {1'b0, root_r})};
      end
    end
  end

  // Zero test of the root as it stands after the current step, so the last
  // root step already counts.
  assign stat.mag_zero = (root_r[30:0] == '0) && (sq_try < trial);

  assign out_data.prod_x       = res_r[0];
  assign out_data.prod_y       = res_r[1];
  assign out_data.prod_z       = res_r[2];
  assign out_data.prod_w       = res_r[3];
  assign out_data.renormalized = renorm && (root_r != '0);

endmodule

// File: design/quaternion_multiply_renormalize_core.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_renormalize_core: Hamilton product with periodic
// renormalization to unit magnitude.
//
// The input channel (in_valid/in_ready/in_data) takes one word holding two
// Q2.30 quaternions; the result channel (out_valid/out_ready/out_data)
// returns one word with the saturated product and a renormalized flag.
// The block works on one word at a time. A plain product makes sixteen
// passes through the product multiplier and one step that saturates the
// sums and checks the call count. A renormalizing product adds four
// squares and the root init, 32 root steps and four bit-serial divides,
// one per component. When the magnitude is zero the divides are skipped.
// Each product is followed by the result state and then the idle state, in
// which the next word is taken. in_ready is high only while idle. A stalled
// receiver holds the result in the output registers; nothing new is taken
// until that word leaves. After reset the period is 97 and the call counter
// is zero. cfg_we writes the period, to be used while the block is idle.
// ----------------------------------------------------------------------------
module quaternion_multiply_renormalize_core
  import qmr_pkg::*;
#(
  parameter logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_RESET
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qmr_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qmr_out_t            out_data,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data
);

  qmr_cmd_t  cmd;
  qmr_stat_t stat;
  logic      renorm;

  // Controller keeps the sequence and the call counter; renorm tells the
  // datapath the word went through the root and, unless zero, the divides.
  qmr_ctrl #(.RESET_PERIOD(RESET_PERIOD)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cfg_we, .cfg_data, .stat, .cmd, .renorm
  );

  qmr_dp u_dp (
    .clk, .in_data, .cmd, .renorm, .stat, .out_data
  );

endmodule

// File: test/quaternion_multiply_renormalize_checker.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_renormalize_checker: result predictor and comparator.
// Watches both channels, computes the expected Hamilton product of every
// accepted word and compares each accepted result word in order.
// ----------------------------------------------------------------------------
module quaternion_multiply_renormalize_checker
  import qmr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  qmr_in_t             in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  qmr_out_t            out_data,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data,
  output int                  error_count,
  output int                  pending
);

  logic [PERIOD_W-1:0] period_q;
  logic [CNT_W-1:0]    calls_q;
  qmr_out_t            product_fifo[$];

  function automatic logic signed [63:0] fx_mul(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [63:0] full;
    full = 64'(p) * 64'(q);
    return full >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic predict_product(qmr_in_t d);
    logic signed [31:0] r[4];
    logic [63:0] hi, lo, sq, m, mag, q;
    qmr_out_t o;
    r[0] = sat32(fx_mul(d.b_w, d.a_x) + fx_mul(d.a_w, d.b_x) + fx_mul(d.a_y, d.b_z)
                 - fx_mul(d.a_z, d.b_y));
    r[1] = sat32(fx_mul(d.b_w, d.a_y) + fx_mul(d.a_w, d.b_y) + fx_mul(d.a_z, d.b_x)
                 - fx_mul(d.a_x, d.b_z));
    r[2] = sat32(fx_mul(d.b_w, d.a_z) + fx_mul(d.a_w, d.b_z) + fx_mul(d.a_x, d.b_y)
                 - fx_mul(d.a_y, d.b_x));
    r[3] = sat32(fx_mul(d.a_w, d.b_w) - fx_mul(d.a_x, d.b_x) - fx_mul(d.a_y, d.b_y)
                 - fx_mul(d.a_z, d.b_z));
    o.renormalized = 1'b0;
    calls_q = calls_q + 1'b1;
    if (calls_q > {1'b0, period_q}) begin
      calls_q = '0;
      hi = 0;
      lo = 0;
      for (int i = 0; i < 4; i++) begin
        sq = 64'(r[i]) * 64'(r[i]);
        hi += sq >> 2;
        lo += sq & 64'd3;
      end
      m = root64(hi + (lo >> 2));
      if (m != 0) begin
        o.renormalized = 1'b1;
        for (int i = 0; i < 4; i++) begin
          mag = r[i] < 0 ? 64'(-64'(r[i])) : 64'(r[i]);
          q = (mag << 29) / m;
          r[i] = sat32(r[i] < 0 ? -$signed(q) : $signed(q));
        end
      end
    end
    o.prod_x = r[0];
    o.prod_y = r[1];
    o.prod_z = r[2];
    o.prod_w = r[3];
    product_fifo.push_back(o);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    qmr_out_t e;
    if (!rst_n) begin
      period_q = PERIOD_RESET;
      calls_q  = '0;
    end else begin
      if (cfg_we) period_q = cfg_data;
      if (out_valid && out_ready) begin
        if (product_fifo.size() == 0) begin
          report_mismatch("unexpected word", out_data.prod_x, 0);
        end else begin
          e = product_fifo.pop_front();
          if (out_data.prod_x !== e.prod_x) report_mismatch("prod_x", out_data.prod_x, e.prod_x);
          if (out_data.prod_y !== e.prod_y) report_mismatch("prod_y", out_data.prod_y, e.prod_y);
          if (out_data.prod_z !== e.prod_z) report_mismatch("prod_z", out_data.prod_z, e.prod_z);
          if (out_data.prod_w !== e.prod_w) report_mismatch("prod_w", out_data.prod_w, e.prod_w);
          if (out_data.renormalized !== e.renormalized)
            report_mismatch("renormalized", out_data.renormalized, e.renormalized);
        end
      end
      if (in_valid && in_ready) predict_product(in_data);
    end
    pending = product_fifo.size();
  end

endmodule

// File: test/quaternion_multiply_renormalize_core_tb.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_renormalize_core_tb: stimulus and verdict.
// Drives directed and random quaternion pairs through several idling phases
// and renormalization periods; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module quaternion_multiply_renormalize_core_tb;
  import qmr_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  qmr_in_t             in_data;
  logic                out_valid;
  logic                out_ready;
  qmr_out_t            out_data;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_data;
  int                  error_count;
  int                  pending;

  // Idling percentages for the sender and the receiver, changed per phase.
  int send_idle_pct;
  int recv_stall_pct;
  // While set, the receiver holds off entirely so the block backs up.
  bit hold_recv;

  quaternion_multiply_renormalize_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  quaternion_multiply_renormalize_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .error_count(error_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout for the whole run; allow plenty of margin across all phases.
  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver draws ready every cycle from the current stall rate.
  always @(posedge clk) begin
    if (!rst_n || hold_recv) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Picks a component value, biased toward extremes and unit-range values.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h40000000;
      3: return 32'hc0000000;
      4: return 32'h0;
      5, 6: return $urandom;
      default: return 32'($signed($urandom_range(32'h7fffffff)) >>> 1) ^
                       ($urandom_range(1) ? 32'hffffffff : 32'h0);
    endcase
  endfunction

  // Offers one word and waits until it is accepted. The valid stays high
  // across back-to-back words, and is lowered only for an idle gap.
  task automatic send_word(qmr_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(int n);
    qmr_in_t d;
    for (int i = 0; i < n; i++) begin
      d = {pick_component(), pick_component(), pick_component(), pick_component(),
           pick_component(), pick_component(), pick_component(), pick_component()};
      send_word(d);
    end
    in_valid <= 1'b0;
  endtask

  // Waits until every expected word has come back, then lets the block
  // settle before the period register is touched.
  task automatic drain_and_set_period(logic [PERIOD_W-1:0] p);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    qmr_in_t d;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: period 0 renormalizes every word, which exercises the root
    // and divides on extreme inputs, the zero-magnitude pass-through and
    // saturation of the sums.
    drain_and_set_period(16'd0);
    send_word('0);
    send_word({8{32'h7fffffff}});
    send_word({8{32'h80000000}});
    send_word({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    send_word({32'h0, 32'h0, 32'h0, 32'h40000000, 32'h0, 32'h0, 32'h0, 32'h40000000});
    send_word({32'h40000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h40000000, 32'h0, 32'h0});
    send_word({32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1});
    send_word({32'hffffffff, 32'h1, 32'hffffffff, 32'h1,
               32'h1, 32'hffffffff, 32'h1, 32'hffffffff});
    // Plain products at the reset-like period, then a lowered period when the
    // counter already exceeds it.
    drain_and_set_period(16'd97);
    send_word({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    send_word({32'h20000000, 32'h10000000, 32'hf0000000, 32'h30000000,
               32'hc0000000, 32'h08000000, 32'h00000001, 32'hffffffff});
    for (int i = 0; i < 6; i++) send_random(1);
    drain_and_set_period(16'd2);
    send_random(4);
    in_valid <= 1'b0;

    // No idling, period 3.
    drain_and_set_period(16'd3);
    send_random(400);
    // Sender idle 84 percent, period 1.
    drain_and_set_period(16'd1);
    send_idle_pct = 84;
    send_random(400);
    // Receiver stalls 84 percent, period 65535 (never renormalizes here).
    drain_and_set_period(16'd65535);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    send_random(400);
    // Both idle 30 percent, period 10.
    drain_and_set_period(16'd10);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    send_random(400);

    // Long receiver hold-off while the sender keeps offering words.
    drain_and_set_period(16'd5);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
      end
      send_random(30);
    join
    send_random(370);

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
